// ===== design/i2c_ras_pkg.sv =====
// types, codes and helpers shared by the register access sequencer
package i2c_ras_pkg;

  localparam logic [2:0] MODE_START_READ  = 3'd0;
  localparam logic [2:0] MODE_START_WRITE = 3'd1;
  localparam logic [2:0] MODE_TX_READY    = 3'd2;
  localparam logic [2:0] MODE_RX_BYTE     = 3'd3;
  localparam logic [2:0] MODE_STOP_SEEN   = 3'd4;
  localparam logic [2:0] MODE_ARB_LOST    = 3'd5;

  localparam logic [2:0] STATUS_IDLE   = 3'd0;
  localparam logic [2:0] STATUS_REG    = 3'd1;
  localparam logic [2:0] STATUS_SWITCH = 3'd2;
  localparam logic [2:0] STATUS_RX     = 3'd3;
  localparam logic [2:0] STATUS_TX     = 3'd4;
  localparam logic [2:0] STATUS_ERROR  = 3'd5;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_REG    = 6'b000010,
    PH_SWITCH = 6'b000100,
    PH_RX     = 6'b001000,
    PH_TX     = 6'b010000,
    PH_ERROR  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [6:0] slave_address_out;
    logic       issue_start_tx;
    logic       issue_restart_rx;
    logic       issue_stop;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_position;
    logic [2:0] status;
    logic       wake;
  } res_t;

  function automatic logic [2:0] status_of(phase_t p);
    logic [2:0] s;
    case (p)
      PH_IDLE:   s = STATUS_IDLE;
      PH_REG:    s = STATUS_REG;
      PH_SWITCH: s = STATUS_SWITCH;
      PH_RX:     s = STATUS_RX;
      PH_TX:     s = STATUS_TX;
      PH_ERROR:  s = STATUS_ERROR;
      default:   s = STATUS_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ===== design/i2c_ras_if.sv =====
// handshake interfaces for the event and result channels
interface i2c_ras_cmd_if import i2c_ras_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2c_ras_res_if import i2c_ras_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/i2c_register_access_sequencer_core.sv =====
// register access sequencer core: event register, sequencing logic, result register
// an accepted event is held in the event register, and its result is then registered in the result register
// throughput: one event per cycle while the result channel is not stalled; the phase and counter
// registers update between the event register and the result register
// reset (rst, synchronous): phase idle, counters and held address cleared,
// both pipeline registers empty; no event is accepted while rst is high
module i2c_register_access_sequencer_core import i2c_ras_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  i2c_ras_cmd_if.sink     cmd,
  i2c_ras_res_if.source   rsp
);

  logic       in_valid;
  cmd_t       in_data;
  logic       out_valid;
  res_t       out_data;
  logic       out_free;

  phase_t     phase;
  logic [7:0] reg_address_hold;
  logic [7:0] rx_remaining;
  logic [7:0] tx_remaining;
  logic [7:0] rx_index_count;

  phase_t     phase_next;
  logic [7:0] reg_address_hold_next;
  logic [7:0] rx_remaining_next;
  logic [7:0] tx_remaining_next;
  logic [7:0] rx_index_count_next;
  res_t       res_next;

  assign out_free  = !out_valid || rsp.ready;
  assign cmd.ready = !rst && (!in_valid || out_free);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      in_data <= cmd.data;
    end
  end

  always_comb begin
    phase_next            = phase;
    reg_address_hold_next = reg_address_hold;
    rx_remaining_next     = rx_remaining;
    tx_remaining_next     = tx_remaining;
    rx_index_count_next   = rx_index_count;
    res_next              = '0;
    case (in_data.mode)
      MODE_START_READ, MODE_START_WRITE: begin
        phase_next                 = PH_REG;
        reg_address_hold_next      = in_data.register_address;
        rx_remaining_next          = (in_data.mode == MODE_START_READ) ? in_data.byte_count : 8'd0;
        tx_remaining_next          = (in_data.mode == MODE_START_WRITE) ? in_data.byte_count : 8'd0;
        rx_index_count_next        = 8'd0;
        res_next.slave_address_out = in_data.slave_address;
        res_next.issue_start_tx    = 1'b1;
      end
      MODE_TX_READY: begin
        case (phase)
          PH_REG: begin
            res_next.tx_valid = 1'b1;
            res_next.tx_byte  = reg_address_hold;
            phase_next        = (rx_remaining != 8'd0) ? PH_SWITCH : PH_TX;
          end
          PH_SWITCH: begin
            res_next.issue_restart_rx = 1'b1;
            res_next.issue_stop       = (rx_remaining == 8'd1);
            phase_next                = PH_RX;
          end
          PH_TX: begin
            if (tx_remaining != 8'd0) begin
              res_next.tx_valid   = 1'b1;
              res_next.tx_byte    = in_data.data_byte;
              res_next.data_taken = 1'b1;
              tx_remaining_next   = tx_remaining - 8'd1;
            end else begin
              res_next.issue_stop = 1'b1;
              res_next.wake       = 1'b1;
              phase_next          = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_RX_BYTE: begin
        if (rx_remaining != 8'd0) begin
          res_next.rx_valid    = 1'b1;
          res_next.rx_byte     = in_data.data_byte;
          res_next.rx_position = rx_index_count;
          rx_index_count_next  = rx_index_count + 8'd1;
          rx_remaining_next    = rx_remaining - 8'd1;
        end
        if (rx_remaining_next == 8'd1) begin
          res_next.issue_stop = 1'b1;
        end else if (rx_remaining_next == 8'd0) begin
          res_next.wake = 1'b1;
          phase_next    = PH_IDLE;
        end
      end
      MODE_STOP_SEEN: phase_next = PH_IDLE;
      MODE_ARB_LOST:  phase_next = PH_ERROR;
      default: begin
      end
    endcase
    res_next.status = status_of(phase_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      reg_address_hold <= 8'd0;
      rx_remaining     <= 8'd0;
      tx_remaining     <= 8'd0;
      rx_index_count   <= 8'd0;
      out_valid        <= 1'b0;
    end else begin
      if (in_valid && out_free) begin
        phase            <= phase_next;
        reg_address_hold <= reg_address_hold_next;
        rx_remaining     <= rx_remaining_next;
        tx_remaining     <= tx_remaining_next;
        rx_index_count   <= rx_index_count_next;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
    if (in_valid && out_free) begin
      out_data <= res_next;
    end
  end

  // a start request always leaves the sequencer sending the register address
  a_start_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.issue_start_tx |-> rsp.data.status == STATUS_REG)
    else $error("start request without register address phase");

  // a finished transaction always reports idle
  a_wake_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.wake |-> rsp.data.status == STATUS_IDLE)
    else $error("wake raised outside idle");

  // a consumed write byte is always the byte being transmitted
  a_taken_tx: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.data_taken |-> rsp.data.tx_valid && !rsp.data.rx_valid)
    else $error("write byte taken without transmit");

  // pipeline only moves when the result register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(phase))
    else $error("sequencer advanced while result stalled");

  // state comes out of reset idle
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> phase == PH_IDLE && !out_valid)
    else $error("state not idle after reset");

endmodule
